/* hw/rtl/mfet_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mfet_pkg;

    // Encoder resolution and the unwrap threshold of half a turn.
    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

    // Motor kind codes.
    localparam logic [2:0] KIND_LAST_CHASSIS = 3'd2;
    localparam logic [2:0] KIND_GIMBAL_A     = 3'd3;
    localparam logic [2:0] KIND_GIMBAL_B     = 3'd4;
    localparam logic [2:0] KIND_GIMBAL_C     = 3'd5;

    // Register index of the motor kind register on the configuration port.
    localparam logic REG_MOTOR_KIND = 1'b0;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Classified frame as it travels from the front to the back.
    typedef struct packed {
        logic               calib;
        logic               reuse;
        logic               gimbal;
        logic               chassis;
        logic               clear_turns;
        logic signed [16:0] cal;
        logic [15:0]        second;
        logic [15:0]        third;
        logic [7:0]         heat;
    } mfet_item_t;

    // Frame after the unwrap step.
    typedef struct packed {
        logic               calib;
        logic               gimbal;
        logic               chassis;
        logic [31:0]        total;
        logic [31:0]        prev_total;
        logic signed [16:0] cal;
        logic [15:0]        second;
        logic [15:0]        third;
        logic [7:0]         heat;
    } mfet_step_t;

    // One result item.
    typedef struct packed {
        logic               calibrating;
        logic [31:0]        total_count;
        logic [16:0]        angle_in_turn;
        logic [15:0]        speed_rpm;
        logic [18:0]        speed_dps;
        logic [15:0]        motor_current;
        logic [7:0]         temperature;
    } mfet_result_t;

endpackage

`default_nettype wire

/* hw/rtl/mfet_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mfet_front
    import mfet_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [2:0]  motor_kind,
    input  wire logic        in_valid,
    input  wire logic [15:0] angle_word,
    input  wire logic [15:0] second_word,
    input  wire logic [15:0] third_word,
    input  wire logic [7:0]  heat_byte,
    input  wire logic        push_ready,
    output mfet_item_t       push_item
);

    logic [1:0]         frame_count_reg, frame_count_next;
    logic [15:0]        offset_reg, offset_next;
    logic               calib;
    logic               gimbal;
    logic               chassis;
    logic               keep_offset;
    logic [15:0]        offset_use;
    logic               take;

    assign take        = in_valid && push_ready;
    assign calib       = (frame_count_reg < 2'd2);
    assign gimbal      = (motor_kind == KIND_GIMBAL_A) || (motor_kind == KIND_GIMBAL_C);
    assign chassis     = (motor_kind <= KIND_LAST_CHASSIS) || (motor_kind == KIND_GIMBAL_B);
    assign keep_offset = (motor_kind == KIND_GIMBAL_A) || (motor_kind == KIND_GIMBAL_B);

    // A calibration frame takes its own angle as the offset unless the kind keeps it.
    assign offset_use = (calib && !keep_offset) ? angle_word : offset_reg;

    always_comb begin
        frame_count_next = frame_count_reg;
        offset_next      = offset_reg;
        if (take) begin
            offset_next = offset_use;
            if (frame_count_reg != 2'd3) begin
                frame_count_next = frame_count_reg + 2'd1;
            end
        end
    end

    always_comb begin
        push_item.calib       = calib;
        push_item.reuse       = !calib && !(gimbal || chassis);
        push_item.gimbal      = gimbal;
        push_item.chassis     = chassis;
        push_item.clear_turns = !calib && (motor_kind == KIND_GIMBAL_B);
        push_item.cal         = $signed({angle_word[15], angle_word})
                                - $signed({offset_use[15], offset_use});
        push_item.second      = second_word;
        push_item.third       = third_word;
        push_item.heat        = heat_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= 2'd0;
            offset_reg      <= 16'd0;
        end else begin
            frame_count_reg <= frame_count_next;
            offset_reg      <= offset_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mfet_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module mfet_queue
    import mfet_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire mfet_item_t push_item,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output mfet_item_t      pop_item
);

    mfet_item_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     fill_reg, fill_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (fill_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mfet_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mfet_back
    import mfet_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       pop_valid,
    output logic            pop_ready,
    input  wire mfet_item_t pop_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output mfet_result_t    out_result
);

    localparam logic signed [17:0] HALF_S = 18'(HALF_TURN);
    localparam logic [31:0]        CPT_W  = 32'(COUNTS_PER_TURN);

    // Unwrap state.
    logic signed [16:0] last_cal_reg, last_cal_next;
    logic [15:0]        turn_reg, turn_next;
    logic [31:0]        last_total_reg, last_total_next;

    // Held feedback values.
    logic [15:0]        speed_reg, speed_next;
    logic [15:0]        current_reg, current_next;
    logic [7:0]         heat_reg, heat_next;

    logic               step_valid_reg;
    mfet_step_t         step_reg, step_next;
    logic               out_valid_reg;
    mfet_result_t       out_reg, out_next;

    logic               step_ready;
    logic               take_item;
    logic               move_step;

    logic signed [16:0] cal_eff;
    logic [15:0]        turn_base;
    logic signed [17:0] diff;
    logic [15:0]        turn_step;
    logic [31:0]        total_w;

    logic signed [31:0] delta;
    logic signed [31:0] delta_adj;
    logic signed [31:0] delta_half;
    logic signed [18:0] speed_x;

    assign step_ready = !out_valid_reg || out_ready;
    assign pop_ready  = !step_valid_reg || step_ready;
    assign take_item  = pop_valid && pop_ready;
    assign move_step  = step_valid_reg && step_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Unwrap step on the frame at the head of the queue.
    always_comb begin
        cal_eff   = pop_item.reuse ? last_cal_reg : pop_item.cal;
        turn_base = pop_item.clear_turns ? 16'd0 : turn_reg;
        diff      = $signed({cal_eff[16], cal_eff}) - $signed({last_cal_reg[16], last_cal_reg});
        if (diff > HALF_S) begin
            turn_step = turn_base - 16'd1;
        end else if (diff < -HALF_S) begin
            turn_step = turn_base + 16'd1;
        end else begin
            turn_step = turn_base;
        end
        total_w = {{16{turn_step[15]}}, turn_step} * CPT_W
                  + {{15{cal_eff[16]}}, cal_eff};
    end

    always_comb begin
        last_cal_next   = last_cal_reg;
        turn_next       = turn_reg;
        last_total_next = last_total_reg;

        step_next.calib      = pop_item.calib;
        step_next.gimbal     = pop_item.gimbal;
        step_next.chassis    = pop_item.chassis;
        step_next.prev_total = last_total_reg;
        step_next.cal        = cal_eff;
        step_next.second     = pop_item.second;
        step_next.third      = pop_item.third;
        step_next.heat       = pop_item.heat;
        step_next.total      = pop_item.calib ? 32'd0 : total_w;

        if (take_item) begin
            last_cal_next = cal_eff;
            if (pop_item.calib) begin
                turn_next = 16'd0;
            end else begin
                turn_next       = turn_step;
                last_total_next = total_w;
            end
        end
    end

    // Held values and the result word.
    always_comb begin
        delta      = $signed(step_reg.total - step_reg.prev_total);
        // Halving rounds toward zero, so negative values take one extra count first.
        delta_adj  = delta + $signed({31'd0, delta[31]});
        delta_half = delta_adj >>> 1;

        speed_next   = speed_reg;
        current_next = current_reg;
        heat_next    = heat_reg;
        if (!step_reg.calib) begin
            if (step_reg.gimbal) begin
                speed_next   = delta_half[15:0];
                current_next = step_reg.second;
            end else if (step_reg.chassis) begin
                speed_next   = step_reg.second;
                current_next = step_reg.third;
                heat_next    = step_reg.heat;
            end
        end

        speed_x = $signed({{3{speed_next[15]}}, speed_next});

        out_next.calibrating   = step_reg.calib;
        out_next.total_count   = step_reg.total;
        out_next.angle_in_turn = step_reg.cal;
        out_next.speed_rpm     = speed_next;
        out_next.speed_dps     = (speed_x <<< 2) + (speed_x <<< 1);
        out_next.motor_current = current_next;
        out_next.temperature   = heat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cal_reg   <= '0;
            turn_reg       <= '0;
            last_total_reg <= '0;
            speed_reg      <= '0;
            current_reg    <= '0;
            heat_reg       <= '0;
            step_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            last_cal_reg   <= last_cal_next;
            turn_reg       <= turn_next;
            last_total_reg <= last_total_next;
            if (move_step) begin
                speed_reg   <= speed_next;
                current_reg <= current_next;
                heat_reg    <= heat_next;
            end
            if (pop_ready) begin
                step_valid_reg <= pop_valid;
            end
            if (step_ready) begin
                out_valid_reg <= step_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_item) begin
            step_reg <= step_next;
        end
        if (move_step) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/motor_feedback_encoder_tracker_core.sv */
// An accepted frame reaches m_tvalid through the queue, the step and the output register.
// Throughput: one frame per cycle unless m_tready stalls, set by the back-stage unwrap.
// A two-entry queue parts the input side from the back stage; the result sits in an
// output register, so a stalled consumer does not stop input until the queue fills.
// Reset (aresetn low, synchronous) clears the frame counter, offset, turn count, held
// values, motor kind and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_encoder_tracker_core
    import mfet_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // angle_word[15:0], second_word[31:16], third_word[47:32], heat_byte[55:48]
    input  wire logic [55:0]  s_tdata,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // total_count[31:0], angle_in_turn[48:32], speed_rpm[64:49], speed_dps[83:65],
    // motor_current[99:84], temperature[107:100], zero[111:108]
    output logic [111:0]      m_tdata,
    // calibrating[0]
    output logic              m_tuser
);

    logic [2:0]   motor_kind_reg, motor_kind_next;
    logic         cfg_write;

    mfet_item_t   push_item;
    logic         push_ready;
    mfet_item_t   pop_item;
    logic         pop_valid;
    logic         pop_ready;
    mfet_result_t result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        motor_kind_next = motor_kind_reg;
        if (cfg_write && (paddr[2] == REG_MOTOR_KIND)) begin
            motor_kind_next = pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == REG_MOTOR_KIND) ? {29'd0, motor_kind_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_kind_reg <= 3'd0;
        end else begin
            motor_kind_reg <= motor_kind_next;
        end
    end

    assign s_tready = push_ready;

    mfet_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .motor_kind  (motor_kind_reg),
        .in_valid    (s_tvalid),
        .angle_word  (s_tdata[15:0]),
        .second_word (s_tdata[31:16]),
        .third_word  (s_tdata[47:32]),
        .heat_byte   (s_tdata[55:48]),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    mfet_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    mfet_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.calibrating;
    assign m_tdata = {4'd0, result.temperature, result.motor_current, result.speed_dps,
                      result.speed_rpm, result.angle_in_turn, result.total_count};

endmodule

`default_nettype wire
